// File: rtl/pnm_pkg.sv
// Package for the PNM byte stream decoder: phases, formats, status codes.
// No dependencies.
`default_nettype none
package pnm_pkg;
  localparam int MaxDimDefault = 16384;
  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;
  localparam logic [1:0] FMT_BITMAP = 2'd0;
  localparam logic [1:0] FMT_GREY   = 2'd1;
  localparam logic [1:0] FMT_COLOR  = 2'd2;
  localparam logic [2:0] ST_PIXEL      = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_BAD_WIDTH  = 3'd2;
  localparam logic [2:0] ST_BAD_HEIGHT = 3'd3;
  localparam logic [2:0] ST_BAD_MAXVAL = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd5;
  localparam logic [31:0] OPAQUE = 32'hff000000;
  localparam logic [31:0] WHITE  = 32'hffffffff;

  // One decoded byte's worth of results.
  typedef struct packed {
    logic [3:0]  count;
    logic [2:0]  status;
    logic [31:0] pixel;
    logic [7:0]  row_end;
    logic [7:0]  image_end;
    logic        bits8;
  } pnm_batch_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction
endpackage
`default_nettype wire

// File: rtl/pnm_parse.sv
// Parser: takes one registered byte and updates the decoder state, producing
// a batch of up to eight results. Depends on pnm_pkg.
`default_nettype none
module pnm_parse #(
  parameter int MAX_DIMENSION = pnm_pkg::MaxDimDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          c,
  input  wire logic                restart,
  output pnm_pkg::pnm_batch_t      batch
);
  localparam logic [16:0] MaxDim = 17'(MAX_DIMENSION);

  logic [2:0]  parse_phase, parse_phase_next;
  logic        in_comment, in_comment_next;
  logic [1:0]  image_format, image_format_next;
  logic        raw_encoding, raw_encoding_next;
  logic [15:0] number_accumulator, number_accumulator_next;
  logic        digit_pending, digit_pending_next;
  logic [14:0] image_width, image_width_next;
  logic [14:0] image_height, image_height_next;
  logic [14:0] column_count, column_count_next;
  logic [14:0] row_count, row_count_next;
  logic [1:0]  channel_index, channel_index_next;
  logic [23:0] partial_color, partial_color_next;
  logic [1:0]  token_chars, token_chars_next;

  // Working copies after the restart clear.
  logic [2:0]  ph;
  logic        cm;
  logic [1:0]  fmt, ch, tk;
  logic        raw, dp;
  logic [15:0] acc;
  logic [14:0] wd, ht, col, row;
  logic [23:0] pc;
  logic [19:0] acc10;
  logic [16:0] dec;
  logic [7:0]  second, v8;
  logic        pix_one, pix_eight;
  logic [31:0] pix_val;
  logic [15:0] col_sum;
  logic [14:0] remaining;
  logic        row_hit8;
  logic [3:0]  k_hit;
  logic [23:0] pc_new;

  assign ph  = restart ? pnm_pkg::PH_MAGIC : parse_phase;
  assign cm  = restart ? 1'b0 : in_comment;
  assign fmt = restart ? 2'd0 : image_format;
  assign raw = restart ? 1'b0 : raw_encoding;
  assign acc = restart ? 16'd0 : number_accumulator;
  assign dp  = restart ? 1'b0 : digit_pending;
  assign wd  = restart ? 15'd0 : image_width;
  assign ht  = restart ? 15'd0 : image_height;
  assign col = restart ? 15'd0 : column_count;
  assign row = restart ? 15'd0 : row_count;
  assign ch  = restart ? 2'd0 : channel_index;
  assign pc  = restart ? 24'd0 : partial_color;
  assign tk  = restart ? 2'd0 : token_chars;

  assign acc10 = {4'd0, acc} * 20'd10 + {16'd0, c[3:0]};
  assign second = acc[15:8];
  assign v8 = acc10[7:0];
  assign remaining = wd - col;

  always_comb begin
    parse_phase_next = ph;
    in_comment_next = cm;
    image_format_next = fmt;
    raw_encoding_next = raw;
    number_accumulator_next = acc;
    digit_pending_next = dp;
    image_width_next = wd;
    image_height_next = ht;
    column_count_next = col;
    row_count_next = row;
    channel_index_next = ch;
    partial_color_next = pc;
    token_chars_next = tk;
    batch = '0;
    pix_one = 1'b0;
    pix_eight = 1'b0;
    pix_val = '0;
    dec = '0;
    col_sum = '0;
    row_hit8 = 1'b0;
    k_hit = '0;
    pc_new = '0;
    if (ph >= pnm_pkg::PH_STOP) begin
      // Stopped until restart.
    end else if (cm) begin
      if (c == 8'h0a) in_comment_next = 1'b0;
    end else if (ph < pnm_pkg::PH_PIXELS) begin
      if (pnm_pkg::is_ws(c) || c == 8'h23) begin
        if (c == 8'h23) in_comment_next = 1'b1;
        if (tk != 2'd0) begin
          token_chars_next = 2'd0;
          number_accumulator_next = '0;
          digit_pending_next = 1'b0;
          case (ph)
            pnm_pkg::PH_MAGIC: begin
              if (tk < 2'd2 || acc[7:0] != 8'h50 || second < 8'h31 || second > 8'h36)
              begin
                batch.status = pnm_pkg::ST_BAD_MAGIC;
                batch.count = 4'd1;
                parse_phase_next = pnm_pkg::PH_STOP;
                number_accumulator_next = acc;
                digit_pending_next = dp;
              end else begin
                image_format_next = (second == 8'h31 || second == 8'h34) ?
                  pnm_pkg::FMT_BITMAP : (second == 8'h32 || second == 8'h35) ?
                  pnm_pkg::FMT_GREY : pnm_pkg::FMT_COLOR;
                raw_encoding_next = second > 8'h33;
                parse_phase_next = pnm_pkg::PH_WIDTH;
              end
            end
            pnm_pkg::PH_WIDTH: begin
              if (acc == 16'd0 || (fmt == pnm_pkg::FMT_BITMAP && acc[2:0] != 3'd0))
              begin
                batch.status = pnm_pkg::ST_BAD_WIDTH;
              end else if ({1'b0, acc} > MaxDim) begin
                batch.status = pnm_pkg::ST_TOO_LARGE;
              end else begin
                image_width_next = acc[14:0];
                parse_phase_next = pnm_pkg::PH_HEIGHT;
              end
            end
            pnm_pkg::PH_HEIGHT: begin
              if (acc == 16'd0) batch.status = pnm_pkg::ST_BAD_HEIGHT;
              else if ({1'b0, acc} > MaxDim) batch.status = pnm_pkg::ST_TOO_LARGE;
              else begin
                image_height_next = acc[14:0];
                parse_phase_next = (fmt == pnm_pkg::FMT_BITMAP) ?
                  pnm_pkg::PH_PIXELS : pnm_pkg::PH_MAXVAL;
              end
            end
            default: begin
              if (acc == 16'd0 || acc > 16'd255) batch.status = pnm_pkg::ST_BAD_MAXVAL;
              else parse_phase_next = pnm_pkg::PH_PIXELS;
            end
          endcase
          if (batch.status != pnm_pkg::ST_PIXEL) begin
            batch.count = 4'd1;
            parse_phase_next = pnm_pkg::PH_STOP;
            number_accumulator_next = acc;
            digit_pending_next = dp;
          end
        end
      end else begin
        // Token character.
        if (ph == pnm_pkg::PH_MAGIC) begin
          if (tk == 2'd0) number_accumulator_next = {8'd0, c};
          else if (tk == 2'd1) number_accumulator_next = {c, acc[7:0]};
        end else begin
          if (tk == 2'd0 || dp) begin
            if (pnm_pkg::is_digit(c)) begin
              dec = (tk == 2'd0) ? {13'd0, c[3:0]} : 17'(acc10);
              number_accumulator_next = (acc10 > 20'hffff && tk != 2'd0) ? 16'hffff :
                                        dec[15:0];
              digit_pending_next = 1'b1;
            end else begin
              number_accumulator_next = (tk == 2'd0) ? 16'd0 : acc;
              digit_pending_next = 1'b0;
            end
          end
        end
        if (tk < 2'd2) token_chars_next = tk + 2'd1;
      end
    end else begin
      // Image data.
      if (raw) begin
        if (fmt == pnm_pkg::FMT_BITMAP) pix_eight = 1'b1;
        else if (fmt == pnm_pkg::FMT_GREY) begin
          pix_one = 1'b1;
          pix_val = pnm_pkg::OPAQUE | {8'd0, c, c, c};
        end else begin
          pc_new = pc | (ch == 2'd0 ? {c, 16'd0} : ch == 2'd1 ? {8'd0, c, 8'd0} :
                         {16'd0, c});
          if (ch == 2'd2) begin
            pix_one = 1'b1;
            pix_val = pnm_pkg::OPAQUE | {8'd0, pc_new};
            channel_index_next = 2'd0;
            partial_color_next = '0;
          end else begin
            channel_index_next = ch + 2'd1;
            partial_color_next = pc_new;
          end
        end
      end else if (fmt == pnm_pkg::FMT_BITMAP) begin
        if (c == 8'h30) begin
          pix_one = 1'b1;
          pix_val = pnm_pkg::WHITE;
        end else if (c == 8'h31) begin
          pix_one = 1'b1;
        end
      end else if (pnm_pkg::is_digit(c)) begin
        number_accumulator_next = acc10[15:0];
        digit_pending_next = 1'b1;
      end else if (pnm_pkg::is_ws(c)) begin
        if (dp) begin
          number_accumulator_next = '0;
          digit_pending_next = 1'b0;
          if (fmt == pnm_pkg::FMT_GREY) begin
            pix_one = 1'b1;
            pix_val = pnm_pkg::OPAQUE | {8'd0, acc[7:0], acc[7:0], acc[7:0]};
          end else begin
            pc_new = pc | (ch == 2'd0 ? {acc[7:0], 16'd0} :
                           ch == 2'd1 ? {8'd0, acc[7:0], 8'd0} : {16'd0, acc[7:0]});
            if (ch == 2'd2) begin
              pix_one = 1'b1;
              pix_val = pnm_pkg::OPAQUE | {8'd0, pc_new};
              channel_index_next = 2'd0;
              partial_color_next = '0;
            end else begin
              channel_index_next = ch + 2'd1;
              partial_color_next = pc_new;
            end
          end
        end
      end else begin
        number_accumulator_next = '0;
        digit_pending_next = 1'b0;
      end
      // Column and row bookkeeping for one pixel.
      if (pix_one) begin
        batch.count = 4'd1;
        batch.pixel = pix_val;
        col_sum = {1'b0, col} + 16'd1;
        if (col_sum >= {1'b0, wd}) begin
          batch.row_end[0] = 1'b1;
          column_count_next = '0;
          row_count_next = row + 15'd1;
          if (row + 15'd1 >= ht) begin
            batch.image_end[0] = 1'b1;
            parse_phase_next = pnm_pkg::PH_STOP;
          end
        end else begin
          column_count_next = col_sum[14:0];
        end
      end
      // Eight bitmap pixels; width is a multiple of eight, so a row ends only
      // on the last of the eight.
      if (pix_eight) begin
        batch.bits8 = 1'b1;
        batch.pixel = {24'd0, c};
        batch.count = 4'd8;
        row_hit8 = remaining <= 15'd8;
        k_hit = row_hit8 ? 4'(remaining[3:0] - 4'd1) : 4'd7;
        if (row_hit8) begin
          batch.row_end[k_hit[2:0]] = 1'b1;
          column_count_next = '0;
          row_count_next = row + 15'd1;
          if (row + 15'd1 >= ht) begin
            batch.image_end[k_hit[2:0]] = 1'b1;
            batch.count = k_hit + 4'd1;
            parse_phase_next = pnm_pkg::PH_STOP;
          end
        end else begin
          column_count_next = col + 15'd8;
        end
      end
    end
  end

  // State registers advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= pnm_pkg::PH_MAGIC;
      in_comment <= 1'b0;
      image_format <= '0;
      raw_encoding <= 1'b0;
      number_accumulator <= '0;
      digit_pending <= 1'b0;
      image_width <= '0;
      image_height <= '0;
      column_count <= '0;
      row_count <= '0;
      channel_index <= '0;
      partial_color <= '0;
      token_chars <= '0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      in_comment <= in_comment_next;
      image_format <= image_format_next;
      raw_encoding <= raw_encoding_next;
      number_accumulator <= number_accumulator_next;
      digit_pending <= digit_pending_next;
      image_width <= image_width_next;
      image_height <= image_height_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
      channel_index <= channel_index_next;
      partial_color <= partial_color_next;
      token_chars <= token_chars_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/pnm_drain.sv
// Output stage: holds one batch and hands its results out one per cycle while the receiver is ready.
// Depends on pnm_pkg.
`default_nettype none
module pnm_drain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire pnm_pkg::pnm_batch_t batch,
  output logic                     free,
  output logic                     tvalid,
  input  wire logic                tready,
  output logic [39:0]              tdata,
  output logic                     tlast
);
  pnm_pkg::pnm_batch_t held;
  logic [3:0] idx;
  logic       busy;
  logic       last;
  logic [31:0] px;

  assign last = (idx + 4'd1) == held.count;
  assign tvalid = busy;
  assign tlast = last;
  assign free = !busy || (tready && last);
  assign px = held.bits8 ? (held.pixel[3'd7 - idx[2:0]] ? 32'd0 : pnm_pkg::WHITE) :
              held.pixel;
  assign tdata = {3'd0, held.image_end[idx[2:0]], held.row_end[idx[2:0]], px,
                  held.status};

  // Batch register and result index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (free) begin
      busy <= load && batch.count != 4'd0;
      idx <= '0;
    end else if (tready) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) held <= batch;
  end
endmodule
`default_nettype wire

// File: rtl/pnm_byte_stream_decoder.sv
// Top level of the PNM byte stream decoder: input register, parser, output stage.
// Depends on pnm_pkg, pnm_parse and pnm_drain.
//
// Channel | Dir | Payload
// s_axis  | in  | tdata[7:0] in_byte, tuser restart
// m_axis  | out | tdata status, pixel_argb, row_end, image_end; tlast last_in_run
//
// A byte is accepted every cycle while each byte yields at most one result and the output is not stalled.
// A raw bitmap byte yields eight pixels, so input stalls while the output stage
// drains them. Header bytes with no result do not occupy the output stage.
// Reset clears all parser state; restart on a byte clears it before that byte.
// Output stalls back up through the output stage into the input register.
`default_nettype none
module pnm_byte_stream_decoder #(
  parameter int MAX_DIMENSION = pnm_pkg::MaxDimDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // in_byte
  input  wire logic        s_axis_tuser,  // restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // status[2:0], pixel_argb[34:3],
                                          // row_end[35], image_end[36], zero fill
  output logic             m_axis_tlast   // last_in_run
);
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       free;
  logic       step;
  pnm_pkg::pnm_batch_t batch;

  assign step = in_valid && free;
  assign s_axis_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_axis_tready) in_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_restart <= s_axis_tuser;
    end
  end

  pnm_parse #(.MAX_DIMENSION(MAX_DIMENSION)) u_parse (
    .clk(clk), .rst(rst), .step(step), .c(in_byte), .restart(in_restart),
    .batch(batch)
  );

  pnm_drain u_drain (
    .clk(clk), .rst(rst), .load(step), .batch(batch), .free(free),
    .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tdata(m_axis_tdata),
    .tlast(m_axis_tlast)
  );

  // Error results carry no pixel and no flags.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != pnm_pkg::ST_PIXEL |->
      m_axis_tdata[36:3] == 34'd0 && m_axis_tlast)
    else $error("error result with payload");
  // Image end implies row end.
  a_img_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[36] |-> m_axis_tdata[35] && m_axis_tlast)
    else $error("image end without row end");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
endmodule
`default_nettype wire

// File: sim/tb_pnm_byte_stream_decoder.sv
// Self-checking testbench for the PNM byte stream decoder.
// Drives PNM files byte by byte on the input stream and predicts every result.
// Depends on pnm_pkg and pnm_byte_stream_decoder.
`timescale 1ns / 100ps
`default_nettype none
module tb_pnm_byte_stream_decoder;

  localparam int MAX_DIM = 16384;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_LEN = 300;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pixel;
    logic        row_end;
    logic        image_end;
    logic        last;
  } pnm_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  pnm_byte_stream_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predicted decoder state.
  logic [2:0]  phase;
  logic        comment;
  logic [1:0]  fmt;
  logic        raw;
  int unsigned acc;
  logic        digits;
  int unsigned width_px;
  int unsigned height_px;
  int unsigned col;
  int unsigned row;
  int unsigned chan;
  logic [23:0] color;
  int unsigned tok_len;

  pnm_result_t pending_pixels[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_off_req;
  logic        hold_off_ack;
  int          hold_off_cycles;
  int          mismatches;
  int          pixels_seen;
  int          errors_seen;
  int          bytes_sent;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic clear_decoder();
    phase = pnm_pkg::PH_MAGIC; comment = 0; fmt = pnm_pkg::FMT_BITMAP; raw = 0;
    acc = 0; digits = 0;
    width_px = 0; height_px = 0; col = 0; row = 0; chan = 0; color = 0; tok_len = 0;
  endtask

  task automatic push_result(input logic [2:0] st, input logic [31:0] px,
                             input logic re, input logic ie);
    pnm_result_t r;
    r.status = st; r.pixel = px; r.row_end = re; r.image_end = ie; r.last = 0;
    pending_pixels.push_back(r);
  endtask

  task automatic report_fault(input logic [2:0] st);
    push_result(st, 32'h0, 1'b0, 1'b0);
    phase = pnm_pkg::PH_STOP;
  endtask

  task automatic pixel_out(input logic [31:0] px);
    logic re;
    logic ie;
    re = 0; ie = 0;
    if (phase != pnm_pkg::PH_PIXELS) return;
    col++;
    if (col >= width_px) begin
      re = 1; col = 0; row++;
      if (row >= height_px) begin
        ie = 1; phase = pnm_pkg::PH_STOP;
      end
    end
    push_result(pnm_pkg::ST_PIXEL, px, re, ie);
  endtask

  task automatic add_channel(input logic [7:0] v);
    color = color | (24'(v) << (16 - 8 * chan));
    chan++;
    if (chan >= 3) begin
      chan = 0;
      pixel_out(pnm_pkg::OPAQUE | {8'h0, color});
      color = 0;
    end
  endtask

  task automatic close_token();
    logic [7:0] first;
    logic [7:0] second;
    if (phase == pnm_pkg::PH_MAGIC) begin
      first = acc[7:0];
      second = (tok_len >= 2) ? acc[15:8] : 8'h0;
      if (first != "P" || second < "1" || second > "6") begin
        report_fault(pnm_pkg::ST_BAD_MAGIC);
        return;
      end
      fmt = 2'((second - 8'h31) % 3);
      raw = second > "3";
      phase = pnm_pkg::PH_WIDTH;
    end else if (phase == pnm_pkg::PH_WIDTH) begin
      if (acc < 1 || (fmt == pnm_pkg::FMT_BITMAP && acc[2:0] != 0)) begin
        report_fault(pnm_pkg::ST_BAD_WIDTH); return;
      end
      if (acc > MAX_DIM) begin
        report_fault(pnm_pkg::ST_TOO_LARGE); return;
      end
      width_px = acc; phase = pnm_pkg::PH_HEIGHT;
    end else if (phase == pnm_pkg::PH_HEIGHT) begin
      if (acc < 1) begin
        report_fault(pnm_pkg::ST_BAD_HEIGHT); return;
      end
      if (acc > MAX_DIM) begin
        report_fault(pnm_pkg::ST_TOO_LARGE); return;
      end
      height_px = acc;
      phase = (fmt == pnm_pkg::FMT_BITMAP) ? pnm_pkg::PH_PIXELS : pnm_pkg::PH_MAXVAL;
    end else begin
      if (acc < 1 || acc > 255) begin
        report_fault(pnm_pkg::ST_BAD_MAXVAL); return;
      end
      phase = pnm_pkg::PH_PIXELS;
    end
    acc = 0; digits = 0;
  endtask

  // Works out the results of one accepted byte and queues them.
  task automatic decode_byte(input logic [7:0] c, input logic restart);
    int prior_count;
    prior_count = pending_pixels.size();
    if (restart) clear_decoder();
    if (phase >= pnm_pkg::PH_STOP) return;
    if (comment) begin
      if (c == 8'h0a) comment = 0;
      return;
    end
    if (phase < pnm_pkg::PH_PIXELS) begin
      if (ws(c) || c == "#") begin
        if (c == "#") comment = 1;
        if (tok_len != 0) begin
          close_token();
          tok_len = 0;
        end
      end else begin
        if (phase == pnm_pkg::PH_MAGIC) begin
          if (tok_len == 0) acc = 32'(c);
          else if (tok_len == 1) acc = acc | (int'(c) << 8);
        end else begin
          if (tok_len == 0) begin
            acc = 0; digits = 1;
          end
          if (digits) begin
            if (dig(c)) begin
              acc = acc * 10 + (c - 8'h30);
              if (acc > 65535) acc = 65535;
            end else digits = 0;
          end
        end
        if (tok_len < 2) tok_len++;
      end
    end else if (raw) begin
      if (fmt == pnm_pkg::FMT_BITMAP) begin
        for (int b = 7; b >= 0; b--) pixel_out(c[b] ? 32'h0 : pnm_pkg::WHITE);
      end else if (fmt == pnm_pkg::FMT_GREY) pixel_out(pnm_pkg::OPAQUE | ({8'h0, c, c, c}));
      else add_channel(c);
    end else if (fmt == pnm_pkg::FMT_BITMAP) begin
      if (c == "0") pixel_out(pnm_pkg::WHITE);
      else if (c == "1") pixel_out(32'h0);
    end else if (dig(c)) begin
      acc = (acc * 10 + (c - 8'h30)) & 16'hffff;
      digits = 1;
    end else if (ws(c)) begin
      if (digits) begin
        logic [7:0] v;
        v = acc[7:0]; acc = 0; digits = 0;
        if (fmt == pnm_pkg::FMT_GREY) pixel_out(pnm_pkg::OPAQUE | {8'h0, v, v, v});
        else add_channel(v);
      end
    end else begin
      acc = 0; digits = 0;
    end
    if (pending_pixels.size() > prior_count)
      pending_pixels[pending_pixels.size() - 1].last = 1;
  endtask

  // Offers one byte and waits for its transaction. Valid stays high afterwards
  // so the next byte can follow at once; the idle loop or the drain wait drops it.
  task automatic send_byte(input logic [7:0] c, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(c, restart);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic first_restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first_restart && i == 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off when the test toggles
  // its request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_off_ack <= hold_off_req;
      hold_off_cycles <= 0;
    end else if (hold_off_req != hold_off_ack) begin
      hold_off_ack <= hold_off_req;
      hold_off_cycles <= HOLD_OFF_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  // Compares each result transaction against the oldest prediction.
  always @(posedge clk) begin
    pnm_result_t got;
    pnm_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[2:0];
      got.pixel = m_axis_tdata[34:3];
      got.row_end = m_axis_tdata[35];
      got.image_end = m_axis_tdata[36];
      got.last = m_axis_tlast;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got != want || m_axis_tdata[39:37] != 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected st=%0d px=%h re=%b ie=%b last=%b, ",
                      "got st=%0d px=%h re=%b ie=%b last=%b"},
                     want.status, want.pixel, want.row_end, want.image_end, want.last,
                     got.status, got.pixel, got.row_end, got.image_end, got.last);
        end
        if (got.status == pnm_pkg::ST_PIXEL) pixels_seen++;
        else errors_seen++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_pixels.size());
      $display("FAIL pnm_byte_stream_decoder");
      $finish;
    end
  end

  function automatic string decimal(input int v);
    return $sformatf("%0d", v);
  endfunction

  // Header faults, size limits, comments and odd magic tokens.
  task automatic test_header_cases();
    send_text("Q5 ", 1'b1);
    send_text("P7\n", 1'b1);
    send_text("P", 1'b1); send_byte(8'h20, 1'b0);
    send_text("P1 12 4\n", 1'b1);
    send_text("P2 0 ", 1'b1);
    send_text("P5 16385 ", 1'b1);
    send_text("P5 4 -3 ", 1'b1);
    send_text("P5 4 99999999 ", 1'b1);
    send_text("P6 2 2 0 ", 1'b1);
    send_text("P6 2 2 256\n", 1'b1);
    send_text("P2x #c P\n 3a9 1#x\n0 \xff", 1'b1);
    send_text("P5 2 1 255 \x00\xff", 1'b1);
    send_text("P4 8 1\n\x5a", 1'b1);
    send_text("P1#c\n8 1 01x0 1 0 1 0 1 0 1", 1'b1);
    send_text("P3 1 1 255 300 -7 12 x9 8 \t", 1'b1);
    send_text("P6 1 1 255#z\n\x80\x7f\x01", 1'b1);
    wait_drained();
  endtask

  // Well-formed random images in all six formats, plus noise.
  task automatic test_random_images(input int budget);
    int start;
    int kind;
    int w;
    int h;
    int v;
    string hdr;
    string sep;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      kind = $urandom_range(7);
      if (kind == 7) begin
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), i == 0);
        continue;
      end
      w = (kind % 3 == 0) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 3);
      h = $urandom_range(1, 2);
      if ($urandom_range(3) == 0) sep = " # note\n";
      else sep = "\n";
      hdr = {"P", decimal(kind % 6 + 1), sep, decimal(w), " ", decimal(h)};
      if (kind % 3 != 0) hdr = {hdr, " ", decimal($urandom_range(1, 255))};
      send_text({hdr, "\n"}, 1'b1);
      for (int p = 0; p < w * h * ((kind % 3 == 2) ? 3 : 1); p++) begin
        v = $urandom_range(255);
        case (kind % 6)
          0: send_byte($urandom_range(1) ? "1" : "0", 1'b0);
          3: begin
            if (p % 8 == 0) send_byte(8'(v), 1'b0);
          end
          4, 5: send_byte(8'(v), 1'b0);
          default: send_text({decimal(v), ($urandom_range(1) ? " " : "\n")}, 1'b0);
        endcase
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h0;
    s_axis_tuser = 1'b0;
    hold_off_req = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; bytes_sent = 0;
    clear_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_cases();
    test_random_images(10);
    send_idle_pct = 52; test_random_images(10);
    send_idle_pct = 0; recv_stall_pct = 52; test_random_images(10);
    send_idle_pct = 35; recv_stall_pct = 35; test_random_images(10);

    // Long receiver hold-off while raw bitmap bytes keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off_req <= ~hold_off_req;
    send_text("P4 64 2\n", 1'b1);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();

    $display("Sent %0d bytes; checked %0d pixels and %0d header faults over all formats.",
             bytes_sent, pixels_seen, errors_seen);
    if (mismatches == 0 && pending_pixels.size() == 0) $display("PASS pnm_byte_stream_decoder");
    else $display("FAIL pnm_byte_stream_decoder");
    $finish;
  end
endmodule
`default_nettype wire
